// ===== rtl/wts_pkg.sv =====
// shared constants, types and the memory request bundle of the weighted table sampler
// used by wts_table, wts_ctrl and weighted_table_sampler; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wts_pkg;

  // table geometry
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = ADDR_W + 1;

  // field widths
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned WGT_W  = 16;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned CUM_W  = 24;
  localparam int unsigned PROD_W = FRAC_W + CUM_W;

  // stream payload widths
  localparam int unsigned S_DATA_W = IDX_W + VAL_W + WGT_W + FRAC_W;
  localparam int unsigned M_DATA_W = VAL_W + IDX_W;

  // item kinds carried in tuser
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // reset value of the entry count register
  localparam logic [CNT_W-1:0] ENTRIES_RESET = CNT_W'(TABLE_DEPTH);

  // request bundle from the controller to the table memories
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CUM_W-1:0]  cum_wdata;
    logic [VAL_W-1:0]  val_wdata;
    logic              cum_re;
    logic [ADDR_W-1:0] cum_raddr;
    logic              val_re;
    logic [ADDR_W-1:0] val_raddr;
  } wts_mem_req_t;

endpackage

`default_nettype wire

// ===== rtl/wts_table.sv =====
// value and cumulative weight memories, one write and one registered read port each
// depends on wts_pkg
`timescale 1ns / 1ps
`default_nettype none

module wts_table
  import wts_pkg::*;
(
  input  wire logic             clk_i,
  input  wire wts_mem_req_t     req_i,
  output logic [CUM_W-1:0]      cum_rdata_o,
  output logic [VAL_W-1:0]      val_rdata_o
);

  logic [CUM_W-1:0] cum_mem [TABLE_DEPTH];
  logic [VAL_W-1:0] val_mem [TABLE_DEPTH];

  // cumulative weight memory
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      cum_mem[req_i.waddr] <= req_i.cum_wdata;
    end
    if (req_i.cum_re) begin
      cum_rdata_o <= cum_mem[req_i.cum_raddr];
    end
  end

  // value word memory
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      val_mem[req_i.waddr] <= req_i.val_wdata;
    end
    if (req_i.val_re) begin
      val_rdata_o <= val_mem[req_i.val_raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wts_ctrl.sv =====
// sequencer: table loads, weight scaling, lower-bound search and the output register
// depends on wts_pkg; drives the memories in wts_table
`timescale 1ns / 1ps
`default_nettype none

module wts_ctrl
  import wts_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [CNT_W-1:0]    n_active_i,
  // input stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [S_DATA_W-1:0] s_axis_tdata,
  input  wire logic                s_axis_tuser,
  // output stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [M_DATA_W-1:0]      m_axis_tdata,
  // memory side
  output wts_mem_req_t             mem_req_o,
  input  wire logic [CUM_W-1:0]    cum_rdata_i,
  input  wire logic [VAL_W-1:0]    val_rdata_i
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_SCALE  = 3'd2;
  localparam logic [2:0] ST_SEARCH = 3'd3;
  localparam logic [2:0] ST_PICK   = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [VAL_W-1:0]    val_q, val_d;
  logic [WGT_W-1:0]    wgt_q, wgt_d;
  logic [FRAC_W-1:0]   frac_q, frac_d;
  logic [CUM_W-1:0]    target_q, target_d;
  logic [CNT_W-1:0]    lo_q, lo_d;
  logic [CNT_W-1:0]    hi_q, hi_d;
  logic [ADDR_W-1:0]   mid_q, mid_d;
  logic [ADDR_W-1:0]   pick_q, pick_d;
  logic                out_valid_q, out_valid_d;
  logic [M_DATA_W-1:0] out_data_q, out_data_d;

  logic [IDX_W-1:0]    in_idx;
  logic [VAL_W-1:0]    in_val;
  logic [WGT_W-1:0]    in_wgt;
  logic [FRAC_W-1:0]   in_frac;
  logic                in_xact;
  logic [ADDR_W-1:0]   n_last;
  logic [PROD_W-1:0]   product;
  logic [CNT_W-1:0]    lo_n, hi_n;
  logic [CNT_W:0]      mid_sum;
  logic [CUM_W-1:0]    prev_cum;

  // unpack the input transaction
  assign in_idx  = s_axis_tdata[IDX_W-1:0];
  assign in_val  = s_axis_tdata[IDX_W +: VAL_W];
  assign in_wgt  = s_axis_tdata[IDX_W+VAL_W +: WGT_W];
  assign in_frac = s_axis_tdata[IDX_W+VAL_W+WGT_W +: FRAC_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xact       = s_axis_tvalid && s_axis_tready;
  assign n_last        = ADDR_W'(n_active_i - CNT_W'(1));

  assign product  = PROD_W'(frac_q) * PROD_W'(cum_rdata_i);
  assign prev_cum = (idx_q == '0) ? '0 : cum_rdata_i;

  // one halving step of the lower-bound search
  always_comb begin
    lo_n = lo_q;
    hi_n = hi_q;
    if (cum_rdata_i < target_q) begin
      lo_n = CNT_W'(mid_q) + CNT_W'(1);
    end else begin
      hi_n = CNT_W'(mid_q);
    end
    mid_sum = ({1'b0, lo_n} + {1'b0, hi_n}) >> 1;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    val_d       = val_q;
    wgt_d       = wgt_q;
    frac_d      = frac_q;
    target_d    = target_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    pick_d      = pick_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;

    mem_req_o           = '0;
    mem_req_o.waddr     = ADDR_W'(idx_q);
    mem_req_o.cum_wdata = prev_cum + CUM_W'(wgt_q);
    mem_req_o.val_wdata = val_q;

    unique case (state_q)
      ST_IDLE: begin
        // fetch the previous cumulative weight or the table total up front
        mem_req_o.cum_re    = 1'b1;
        mem_req_o.cum_raddr = (s_axis_tuser == OP_LOAD) ? ADDR_W'(in_idx - IDX_W'(1)) : n_last;
        if (in_xact) begin
          idx_d   = in_idx;
          val_d   = in_val;
          wgt_d   = in_wgt;
          frac_d  = in_frac;
          state_d = (s_axis_tuser == OP_LOAD) ? ST_LOAD : ST_SCALE;
        end
      end
      ST_LOAD: begin
        mem_req_o.we = (CNT_W'(idx_q) < CNT_W'(TABLE_DEPTH));
        state_d      = ST_IDLE;
      end
      ST_SCALE: begin
        // target = fraction times total weight, then start the search at the midpoint
        target_d            = product[PROD_W-1 -: CUM_W];
        lo_d                = '0;
        hi_d                = n_active_i;
        mid_d               = ADDR_W'(n_active_i >> 1);
        mem_req_o.cum_re    = 1'b1;
        mem_req_o.cum_raddr = ADDR_W'(n_active_i >> 1);
        state_d             = ST_SEARCH;
      end
      ST_SEARCH: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) begin
          mid_d               = ADDR_W'(mid_sum);
          mem_req_o.cum_re    = 1'b1;
          mem_req_o.cum_raddr = ADDR_W'(mid_sum);
        end else begin
          // nothing found in an unordered table falls back to the last entry in use
          pick_d              = (lo_n >= n_active_i) ? n_last : ADDR_W'(lo_n);
          mem_req_o.val_re    = 1'b1;
          mem_req_o.val_raddr = pick_d;
          state_d             = ST_PICK;
        end
      end
      ST_PICK: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {IDX_W'(pick_q), val_rdata_i};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    val_q      <= val_d;
    wgt_q      <= wgt_d;
    frac_q     <= frac_d;
    target_q   <= target_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    pick_q     <= pick_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ===== rtl/weighted_table_sampler.sv =====
// top level of the weighted table sampler: entry count register, sequencer and table memories
// depends on wts_pkg, wts_table and wts_ctrl
//
// Usage:
//   s_axis carries one item per transaction; tuser = 0 loads a table entry, tuser = 1 draws a
//   sample. Loads go in ascending index order from index 0; each stores the value word and the
//   running cumulative weight. A sample scales its 16-bit fraction by the cumulative weight of
//   the last entry in use and returns the first entry whose cumulative weight reaches it.
//   m_axis returns one transaction per sample and none per load.
//   The cfg channel writes the entry count (0 acts as 1, above the depth acts as the depth);
//   write it only while no item is in flight.
// Sequence:
//   a load occupies the block while it is accepted and written; a sample while it is accepted,
//   scaled, searched in s steps (up to ceil(log2(n+1)), at most 9 for a full table) and
//   picked, with one cumulative memory read per search step; the search loop through the
//   memory read port sets the rate. The result passes the value read and the output register.
// Reset and stalls:
//   reset empties the output register and sets the entry count to the full depth; the tables
//   hold no defined contents until loaded. A stalled receiver holds the result, the block still
//   takes the next item and finishes it up to the output register, then waits there.
`timescale 1ns / 1ps
`default_nettype none

module weighted_table_sampler
  import wts_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write: entry count
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CNT_W-1:0]    cfg_data_i,
  // input stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // entry_index, entry_value, entry_weight, uniform_fraction
  input  wire logic [S_DATA_W-1:0] s_axis_tdata,
  // op
  input  wire logic                s_axis_tuser,
  // output stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // picked_value, picked_index
  output logic [M_DATA_W-1:0]      m_axis_tdata
);

  logic [CNT_W-1:0] entries_q;
  logic [CNT_W-1:0] n_active;
  wts_mem_req_t     mem_req;
  logic [CUM_W-1:0] cum_rdata;
  logic [VAL_W-1:0] val_rdata;

  // entry count register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= ENTRIES_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      entries_q <= cfg_data_i;
    end
  end

  // clamp to 1..depth
  always_comb begin
    priority if (entries_q == '0) begin
      n_active = CNT_W'(1);
    end else if (entries_q > CNT_W'(TABLE_DEPTH)) begin
      n_active = CNT_W'(TABLE_DEPTH);
    end else begin
      n_active = entries_q;
    end
  end

  wts_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .n_active_i    (n_active),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mem_req_o     (mem_req),
    .cum_rdata_i   (cum_rdata),
    .val_rdata_i   (val_rdata)
  );

  wts_table u_table (
    .clk_i       (clk_i),
    .req_i       (mem_req),
    .cum_rdata_o (cum_rdata),
    .val_rdata_o (val_rdata)
  );

  // a load transaction writes the tables in the following cycle
  a_load_writes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_LOAD)) |=> mem_req.we)
    else $error("load transaction did not write the tables");

  // a sample transaction keeps the input side closed while it runs
  a_sample_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_SAMPLE)) |=> !s_axis_tready)
    else $error("input accepted during a sample");

  // a new result only follows a value memory read
  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(mem_req.val_re, 2))
    else $error("result without a value read");

endmodule

`default_nettype wire

// ===== bench/tb_weighted_table_sampler.sv =====
// self-checking testbench of weighted_table_sampler: directed and random load and sample
// transactions, each result checked against an in-bench cumulative-table search
// depends on wts_pkg and the weighted_table_sampler rtl
`timescale 1ns / 1ps

module tb_weighted_table_sampler;
  import wts_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_CYCLES   = 600;
  localparam int PRINT_LIMIT   = 100;
  localparam int PHASE_COUNT   = 8;
  localparam int PHASE_ITEMS   = 170;

  // one input transaction, unpacked
  typedef struct packed {
    logic              op;
    logic [IDX_W-1:0]  idx;
    logic [VAL_W-1:0]  value_word;
    logic [WGT_W-1:0]  weight;
    logic [FRAC_W-1:0] frac;
  } table_item_t;

  // one expected output transaction
  typedef struct packed {
    logic [VAL_W-1:0] value_word;
    logic [IDX_W-1:0] idx;
  } pick_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CNT_W-1:0]    cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // entry_index, entry_value, entry_weight, uniform_fraction
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  // op
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // picked_value, picked_index
  logic [M_DATA_W-1:0] m_axis_tdata;

  table_item_t      pending_items[$];
  pick_t            expected_picks[$];
  table_item_t      offered_item = '0;
  logic [VAL_W-1:0] value_shadow [TABLE_DEPTH];
  logic [CUM_W-1:0] cum_shadow   [TABLE_DEPTH];
  logic [CNT_W-1:0] count_shadow = ENTRIES_RESET;

  int   src_idle_pct    = 0;
  int   sink_stall_pct  = 0;
  logic hold_trigger    = 1'b0;
  int   hold_left       = 0;
  int   cycle_count     = 0;
  int   error_count     = 0;
  int   loads_done      = 0;
  int   samples_checked = 0;
  int   settings_used   = 0;
  // entries 0 .. filled-1 have been queued for loading
  int   filled          = 0;

  weighted_table_sampler uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // clock
  always #5ns clk_i = ~clk_i;

  // entry count as the search sees it
  function automatic int effective_count(logic [CNT_W-1:0] setting);
    if (setting == 0) return 1;
    if (setting > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(setting);
  endfunction

  // scale the fraction by the total weight, then lower-bound search of the cumulative table
  function automatic pick_t lower_bound_pick(logic [FRAC_W-1:0] frac);
    int                n;
    int                lo;
    int                hi;
    int                mid;
    logic [PROD_W-1:0] product;
    logic [CUM_W-1:0]  target;
    pick_t             pick;
    n       = effective_count(count_shadow);
    product = PROD_W'(frac) * PROD_W'(cum_shadow[n-1]);
    target  = product[PROD_W-1:FRAC_W];
    lo      = 0;
    hi      = n;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (cum_shadow[mid] < target) lo = mid + 1;
      else hi = mid;
    end
    if (lo >= n) lo = n - 1;
    pick.value_word = value_shadow[lo];
    pick.idx        = IDX_W'(lo);
    return pick;
  endfunction

  // accepted transaction: update the shadow tables or queue the expected pick
  task automatic commit_to_shadow(table_item_t item);
    logic [CUM_W-1:0] prev;
    if (item.op == OP_LOAD) begin
      prev = (item.idx == 0) ? '0 : cum_shadow[item.idx - 1];
      cum_shadow[item.idx]   = prev + CUM_W'(item.weight);
      value_shadow[item.idx] = item.value_word;
      loads_done++;
    end else begin
      expected_picks.push_back(lower_bound_pick(item.frac));
    end
  endtask

  task automatic report_mismatch(string what);
    if (error_count < PRINT_LIMIT) $display("check failed at %0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic logic [WGT_W-1:0] random_weight();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return WGT_W'($urandom_range(15));
      default: return WGT_W'($urandom);
    endcase
  endfunction

  function automatic logic [FRAC_W-1:0] random_fraction();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      default: return FRAC_W'($urandom);
    endcase
  endfunction

  task automatic queue_load(int idx, logic [VAL_W-1:0] value_word, logic [WGT_W-1:0] weight);
    table_item_t item;
    item.op         = OP_LOAD;
    item.idx        = IDX_W'(idx);
    item.value_word = value_word;
    item.weight     = weight;
    item.frac       = FRAC_W'($urandom);
    pending_items.push_back(item);
    if (idx + 1 > filled) filled = idx + 1;
  endtask

  task automatic queue_sample(logic [FRAC_W-1:0] frac);
    table_item_t item;
    item.op         = OP_SAMPLE;
    item.idx        = IDX_W'($urandom);
    item.value_word = $urandom;
    item.weight     = WGT_W'($urandom);
    item.frac       = frac;
    pending_items.push_back(item);
  endtask

  // fill the table up to the entries in use, then mix samples with reload runs
  task automatic build_phase(int n, int goal);
    int emitted;
    int roll;
    int start;
    int run;
    emitted = 0;
    while (filled < n) begin
      queue_load(filled, $urandom, random_weight());
      emitted++;
    end
    while (emitted < goal) begin
      roll = $urandom_range(99);
      if (roll < 65) begin
        queue_sample(random_fraction());
        emitted++;
      end else if (roll < 92) begin
        // reload run from any entry whose predecessor is written
        start = $urandom_range(filled < TABLE_DEPTH ? filled : TABLE_DEPTH - 1);
        run   = $urandom_range(8, 1);
        for (int k = 0; k < run && start + k < TABLE_DEPTH; k++) begin
          queue_load(start + k, $urandom, random_weight());
          emitted++;
        end
      end else begin
        // fresh ascending table from entry zero
        run = (n <= 48) ? n : 8;
        for (int k = 0; k < run; k++) begin
          queue_load(k, $urandom, random_weight());
          emitted++;
        end
      end
    end
  endtask

  task automatic write_entry_count(logic [CNT_W-1:0] setting);
    @(posedge clk_i);
    cfg_data_i  <= setting;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i  <= 1'b0;
    count_shadow = setting;
    settings_used++;
  endtask

  // wait for every queued transaction and result, then let a trailing load finish
  // checked at the falling edge so that the driver's updates have settled
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || s_axis_tvalid || expected_picks.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    table_item_t next_item;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) commit_to_shadow(offered_item);
      if (pending_items.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        next_item     = pending_items.pop_front();
        offered_item  <= next_item;
        s_axis_tuser  <= next_item.op;
        s_axis_tdata  <= {next_item.frac, next_item.weight, next_item.value_word, next_item.idx};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_trigger) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // output monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    pick_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_picks.size() == 0) begin
          report_mismatch($sformatf("result %h with no sample waiting", m_axis_tdata));
        end else begin
          want = expected_picks.pop_front();
          if (m_axis_tdata[VAL_W-1:0] !== want.value_word)
            report_mismatch($sformatf("picked_value %h, expected %h",
                                      m_axis_tdata[VAL_W-1:0], want.value_word));
          if (m_axis_tdata[M_DATA_W-1:VAL_W] !== want.idx)
            report_mismatch($sformatf("picked_index %0d, expected %0d",
                                      m_axis_tdata[M_DATA_W-1:VAL_W], want.idx));
          samples_checked++;
        end
      end
      m_axis_tready <= (hold_left == 0) && !hold_trigger &&
                       ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles without draining", cycle_count);
      $display("weighted_table_sampler: mismatch");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    logic [CNT_W-1:0] phase_setting [PHASE_COUNT];
    phase_setting[0] = '0;
    phase_setting[1] = CNT_W'(TABLE_DEPTH);
    phase_setting[2] = '1;
    phase_setting[3] = CNT_W'(1);
    phase_setting[4] = CNT_W'($urandom_range(TABLE_DEPTH - 1, 2));
    phase_setting[5] = CNT_W'($urandom_range(511, TABLE_DEPTH + 1));
    phase_setting[6] = CNT_W'($urandom_range(TABLE_DEPTH, 1));
    phase_setting[7] = CNT_W'(TABLE_DEPTH);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero-weight leading entries, extreme weights and fractions
    write_entry_count(CNT_W'(4));
    queue_load(0, '0, '0);
    queue_load(1, '1, '0);
    queue_load(2, 32'hA5A5_5A5A, '1);
    queue_load(3, $urandom, WGT_W'(1));
    queue_sample('0);
    queue_sample('1);
    queue_sample(FRAC_W'(16'h8000));
    queue_sample(FRAC_W'(1));
    // reloads at zero and one leave the table out of order
    queue_load(0, $urandom, '1);
    queue_sample('1);
    queue_sample(FRAC_W'(16'h4000));
    queue_load(1, $urandom, '1);
    queue_sample(FRAC_W'(16'hC000));
    queue_sample('0);
    wait_drained();
    // count of zero searches a single entry
    write_entry_count('0);
    queue_sample('1);
    queue_sample('0);
    queue_sample(random_fraction());
    wait_drained();

    // random phases over entry-count settings and idling patterns
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p % 4)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 73;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 73;
        end
        default: begin
          src_idle_pct   = 24;
          sink_stall_pct = 24;
        end
      endcase
      write_entry_count(phase_setting[p]);
      build_phase(effective_count(phase_setting[p]), PHASE_ITEMS);
      wait_drained();
    end

    // back-pressure: receiver holds off while samples keep coming
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    write_entry_count(CNT_W'(TABLE_DEPTH));
    @(posedge clk_i);
    hold_trigger <= 1'b1;
    for (int k = 0; k < 60; k++) queue_sample(random_fraction());
    @(posedge clk_i);
    hold_trigger <= 1'b0;
    wait_drained();

    $display("covered %0d table loads and %0d checked samples over %0d entry-count writes,",
             loads_done, samples_checked, settings_used);
    $display("with idle and stall patterns on both sides and one long output hold-off");
    if (error_count == 0) begin
      $display("weighted_table_sampler: match");
    end else begin
      $display("weighted_table_sampler: mismatch");
    end
    $finish;
  end

endmodule
